@@ hw/rtl/dtq_pkg.sv @@
`timescale 1ns / 1ps

package dtq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W = $clog2(QUEUE_DEPTH * 100 + 1);
  localparam int PCT_W = 7;
  localparam int LIMIT_W = 7;

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_SWEEP    = 2'd1,
    REQ_DISPATCH = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_DROP_FULL  = 3'd1,
    ST_SWEEP_DONE = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_NOTHING    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_FIT,
    S_COMPACT,
    S_FILL_GO,
    S_FILL_WAIT
  } state_t;

  typedef struct packed {
    logic [30:0] id;
    logic [30:0] work;
    logic [31:0] arrival;
    logic [32:0] deadline;
  } entry_t;

endpackage

@@ hw/rtl/dtq_fill_div.sv @@
`timescale 1ns / 1ps

module dtq_fill_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dtq_pkg::FILL_W-1:0] dividend,
  input  logic [dtq_pkg::CNT_W-1:0]  divisor,
  output logic                      done,
  output logic [dtq_pkg::PCT_W-1:0]  quotient
);
  import dtq_pkg::*;

  localparam int STEP_W = $clog2(FILL_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FILL_W-1:0] dvd_r, dvd_nxt;
  logic [FILL_W-1:0] quo_r, quo_nxt;
  logic [CNT_W:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    rem_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    rem_t    = {rem_r[CNT_W-1:0], dvd_r[FILL_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(FILL_W);
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[FILL_W-2:0], 1'b0};
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_nxt = rem_t - {1'b0, dvs_r};
        quo_nxt = {quo_r[FILL_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_t;
        quo_nxt = {quo_r[FILL_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = (quo_r > FILL_W'(100)) ? PCT_W'(100) : quo_r[PCT_W-1:0];

endmodule

@@ hw/rtl/deadline_task_queue_dispatch_unit.sv @@
`timescale 1ns / 1ps

// Earliest-deadline-first task queue of 64 entries held in one synchronous RAM.
// start is taken while busy is low; the single result shows for one cycle on
// out_valid and cannot be stalled. Every request ends with a fill
// percentage divide. Sweep makes one compaction pass over the held
// entries. Dispatch, for each task it tries, scans all held entries for
// the least deadline, runs the registered fit multiply, then compacts the
// queue to remove that task; each pass reads the entries one at a time
// through the RAM's one read port.
module deadline_task_queue_dispatch_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [30:0] in_task_id,
  input  logic [30:0] in_work_kinstr,
  input  logic [23:0] in_max_run_ms,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_vcpu_capacity,
  input  logic [31:0] in_vcpu_free_ms,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [30:0] out_task_id,
  output logic [30:0] out_work_kinstr,
  output logic [31:0] out_wait_ms,
  output logic [6:0]  out_removed_count,
  output logic [6:0]  out_queue_count,
  output logic [6:0]  out_fill_percent,
  output logic [31:0] out_not_run_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtq_pkg::*;

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [31:0]      drop_total_r, drop_total_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [31:0]      now_r, now_nxt, free_r, free_nxt;
  logic [15:0]      cap_r, cap_nxt;
  logic             sweep_r, sweep_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt, best_r, best_nxt;
  entry_t           best_e_r, best_e_nxt;
  logic [46:0]      prod_r, prod_nxt;
  logic             big_r, big_nxt, pos_r, pos_nxt;
  logic             disp_r, disp_nxt;
  status_t          status_r, status_nxt;
  logic [30:0]      oid_r, oid_nxt, owork_r, owork_nxt;
  logic [31:0]      wait_r, wait_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PCT_W-1:0] fill_r, fill_nxt;

  logic [CNT_W-1:0] eff_limit;
  logic [32:0]      diff;
  logic             fit, drop_row;
  logic             div_start, div_done;
  logic [PCT_W-1:0] div_q;
  logic [31:0]      drop_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(QUEUE_DEPTH);
    end else if (psel && penable && pwrite && pready) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = {{(32-LIMIT_W){1'b0}}, limit_r};

  assign eff_limit = (limit_r == '0) ? CNT_W'(1) :
                     (limit_r > LIMIT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH) :
                     CNT_W'(limit_r);
  assign drop_inc  = (drop_total_r == 32'hFFFF_FFFF) ? drop_total_r : drop_total_r + 32'd1;

  dtq_fill_div u_fill_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (FILL_W'(held_r) * FILL_W'(100)),
    .divisor  (eff_limit),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_r       <= '0;
      drop_total_r <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      drop_total_r <= drop_total_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    now_r     <= now_nxt;
    free_r    <= free_nxt;
    cap_r     <= cap_nxt;
    sweep_r   <= sweep_nxt;
    rd_ptr_r  <= rd_ptr_nxt;
    wr_ptr_r  <= wr_ptr_nxt;
    rd_idx_r  <= rd_idx_nxt;
    best_r    <= best_nxt;
    best_e_r  <= best_e_nxt;
    prod_r    <= prod_nxt;
    big_r     <= big_nxt;
    pos_r     <= pos_nxt;
    disp_r    <= disp_nxt;
    status_r  <= status_nxt;
    oid_r     <= oid_nxt;
    owork_r   <= owork_nxt;
    wait_r    <= wait_nxt;
    removed_r <= removed_nxt;
    fill_r    <= fill_nxt;
  end

  assign diff = best_e_r.deadline - {1'b0, now_r};
  assign fit  = (now_r > free_r) && (cap_r != '0) && pos_r &&
                (big_r || ({16'd0, best_e_r.work} < prod_r));
  assign drop_row = sweep_r ? ({1'b0, now_r} > rdata_r.deadline) : (rd_idx_r == best_r);

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    drop_total_nxt = drop_total_r;
    now_nxt        = now_r;
    free_nxt       = free_r;
    cap_nxt        = cap_r;
    sweep_nxt      = sweep_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    best_nxt       = best_r;
    best_e_nxt     = best_e_r;
    prod_nxt       = prod_r;
    big_nxt        = big_r;
    pos_nxt        = pos_r;
    disp_nxt       = disp_r;
    status_nxt     = status_r;
    oid_nxt        = oid_r;
    owork_nxt      = owork_r;
    wait_nxt       = wait_r;
    removed_nxt    = removed_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = 1'b0;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = held_r[IDX_W-1:0];
    mem_wdata      = rdata_r;
    mem_raddr      = rd_ptr_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt     = in_now_ms;
          free_nxt    = in_vcpu_free_ms;
          cap_nxt     = in_vcpu_capacity;
          removed_nxt = '0;
          status_nxt  = ST_NOTHING;
          oid_nxt     = '0;
          owork_nxt   = '0;
          wait_nxt    = '0;
          disp_nxt    = 1'b0;
          rd_ptr_nxt  = '0;
          wr_ptr_nxt  = '0;
          state_nxt   = S_FILL_GO;
          case (req_t'(in_req_type))
            REQ_ADD: begin
              if (held_r >= eff_limit || held_r >= CNT_W'(QUEUE_DEPTH)) begin
                drop_total_nxt = drop_inc;
                status_nxt     = ST_DROP_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_wdata.id       = in_task_id;
                mem_wdata.work     = in_work_kinstr;
                mem_wdata.arrival  = in_now_ms;
                mem_wdata.deadline = {1'b0, in_now_ms} + {9'd0, in_max_run_ms};
                held_nxt           = held_r + CNT_W'(1);
                status_nxt         = ST_ADDED;
              end
            end
            REQ_SWEEP: begin
              sweep_nxt  = 1'b1;
              status_nxt = ST_SWEEP_DONE;
              state_nxt  = S_COMPACT;
            end
            REQ_DISPATCH: begin
              sweep_nxt = 1'b0;
              if (held_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      // find least deadline, lowest index on ties
      S_SCAN: begin
        if (rd_ptr_r < held_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (rd_idx_r == '0 || rdata_r.deadline < best_e_r.deadline) begin
            best_nxt   = rd_idx_r;
            best_e_nxt = rdata_r;
          end
        end else if (rd_ptr_r == held_r) begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        pos_nxt   = best_e_r.deadline > {1'b0, now_r};
        big_nxt   = diff[32:31] != 2'b00;
        prod_nxt  = diff[30:0] * cap_r;
        state_nxt = S_FIT;
      end

      S_FIT: begin
        if (fit) begin
          disp_nxt   = 1'b1;
          status_nxt = ST_DISPATCHED;
          oid_nxt    = best_e_r.id;
          owork_nxt  = best_e_r.work;
          wait_nxt   = (now_r >= best_e_r.arrival) ? now_r - best_e_r.arrival : '0;
        end else begin
          drop_total_nxt = drop_inc;
          removed_nxt    = removed_r + CNT_W'(1);
        end
        rd_ptr_nxt = '0;
        wr_ptr_nxt = '0;
        state_nxt  = S_COMPACT;
      end

      // read ahead of the write pointer, kept rows slide down
      S_COMPACT: begin
        if (rd_ptr_r < held_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = rd_ptr_r[IDX_W-1:0];
          rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (drop_row) begin
            if (sweep_r) begin
              removed_nxt = removed_r + CNT_W'(1);
            end
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_r[IDX_W-1:0];
            wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
          end
        end else if (rd_ptr_r == held_r) begin
          held_nxt   = wr_ptr_r;
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          if (sweep_r || disp_r || wr_ptr_r == '0) begin
            state_nxt = S_FILL_GO;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_FILL_GO: begin
        div_start = 1'b1;
        state_nxt = S_FILL_WAIT;
      end

      S_FILL_WAIT: begin
        if (div_done) begin
          fill_nxt      = div_q;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy              = state_r != S_IDLE;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_task_id       = oid_r;
  assign out_work_kinstr   = owork_r;
  assign out_wait_ms       = wait_r;
  assign out_removed_count = 7'(removed_r);
  assign out_queue_count   = 7'(held_r);
  assign out_fill_percent  = fill_r;
  assign out_not_run_total = drop_total_r;

endmodule
